### rtl/tpc_pkg.sv
// Shared types and constants of the tape pulse codec.
package tpc_pkg;

    typedef logic [1:0] t_mode;

    localparam t_mode MODE_STOP = 2'd0;
    localparam t_mode MODE_PLAY = 2'd1;
    localparam t_mode MODE_REC  = 2'd2;

    localparam logic [1:0] FUNC_CTRL = 2'd0;
    localparam logic [1:0] FUNC_EDGE = 2'd1;
    localparam logic [1:0] FUNC_PLAY = 2'd2;

    localparam logic [2:0] BTN_STOP    = 3'd0;
    localparam logic [2:0] BTN_PLAY    = 3'd1;
    localparam logic [2:0] BTN_RECORD  = 3'd2;
    localparam logic [2:0] BTN_REWIND  = 3'd3;
    localparam logic [2:0] BTN_FORWARD = 3'd4;

    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_RECORD = 2'd1;
    localparam logic [1:0] KIND_PULSE  = 2'd2;
    localparam logic [1:0] KIND_EOT    = 2'd3;

    localparam logic [1:0] CFG_VERSION   = 2'd0;
    localparam logic [1:0] CFG_PROTECT   = 2'd1;
    localparam logic [1:0] CFG_IMAGE     = 2'd2;
    localparam logic [1:0] CFG_INIT_LEN  = 2'd3;

    localparam logic [31:0] SHORT_MAX    = 32'd2040;
    localparam logic [31:0] MIN_GAP      = 32'd8;
    localparam logic [23:0] LONG_MAX     = 24'hffffff;
    localparam logic signed [25:0] OVERFLOW_LEN = 26'sd8192;

    typedef struct packed {
        logic [1:0]         func;
        logic               motor;
        logic [2:0]         button_code;
        logic [31:0]        edge_cycle;
        logic [7:0]         tape_byte;
        logic               end_of_tape;
        logic signed [10:0] leftover_cycles;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  out_kind;
        logic [7:0]  record_byte;
        logic [23:0] pulse_cycles;
        logic        last_of_run;
        t_mode       drive_mode;
        logic [31:0] tape_position;
        logic [31:0] tape_length;
    } t_result;

    typedef struct packed {
        t_mode drive;
        t_mode button;
        logic  motor;
        logic  run_busy;
    } t_core_status;

endpackage

### rtl/tpc_in_if.sv
// Input item channel of the tape pulse codec.
interface tpc_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         func;
    logic               motor;
    logic [2:0]         button_code;
    logic [31:0]        edge_cycle;
    logic [7:0]         tape_byte;
    logic               end_of_tape;
    logic signed [10:0] leftover_cycles;

    modport source (
        output valid, func, motor, button_code, edge_cycle, tape_byte, end_of_tape,
               leftover_cycles,
        input  ready
    );
    modport sink (
        input  valid, func, motor, button_code, edge_cycle, tape_byte, end_of_tape,
               leftover_cycles,
        output ready
    );
endinterface

### rtl/tpc_out_if.sv
// Result item channel of the tape pulse codec.
interface tpc_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  out_kind;
    logic [7:0]  record_byte;
    logic [23:0] pulse_cycles;
    logic        last_of_run;
    logic [1:0]  drive_mode;
    logic [31:0] tape_position;
    logic [31:0] tape_length;

    modport source (
        output valid, out_kind, record_byte, pulse_cycles, last_of_run, drive_mode,
               tape_position, tape_length,
        input  ready
    );
    modport sink (
        input  valid, out_kind, record_byte, pulse_cycles, last_of_run, drive_mode,
               tape_position, tape_length,
        output ready
    );
endinterface

### rtl/tpc_cfg_if.sv
// Configuration write channel of the tape pulse codec.
interface tpc_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### rtl/tpc_in_reg.sv
// Input register stage that holds one accepted item for the core.
module tpc_in_reg
    import tpc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    tpc_in_if.sink     i_in,
    input  logic       i_take,
    output logic       o_valid,
    output t_in_item   o_item
);

    logic     r_valid;
    t_in_item r_item;
    logic     accept;

    assign i_in.ready = !r_valid || i_take;
    assign accept     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.func            <= i_in.func;
            r_item.motor           <= i_in.motor;
            r_item.button_code     <= i_in.button_code;
            r_item.edge_cycle      <= i_in.edge_cycle;
            r_item.tape_byte       <= i_in.tape_byte;
            r_item.end_of_tape     <= i_in.end_of_tape;
            r_item.leftover_cycles <= i_in.leftover_cycles;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

### rtl/tpc_core.sv
// Drive state, pulse decoding, edge encoding and the result register.
module tpc_core
    import tpc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_item_valid,
    input  t_in_item     i_item,
    output logic         o_item_take,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data,
    output logic         o_result_valid,
    output t_result      o_result,
    input  logic         i_result_ready,
    output t_core_status o_status
);

    function automatic t_mode drive_of(input logic img, input logic mot, input t_mode btn);
        t_mode d;
        d = MODE_STOP;
        if (img && mot && btn == MODE_PLAY) begin
            d = MODE_PLAY;
        end else if (img && mot && btn == MODE_REC) begin
            d = MODE_REC;
        end
        return d;
    endfunction

    // Configuration registers.
    logic r_version, r_protect, r_image;

    // Drive state.
    logic              r_motor, n_motor;
    t_mode             r_button, n_button;
    t_mode             r_drive, n_drive;
    logic [31:0]       r_pos, n_pos;
    logic [31:0]       r_len, n_len;
    logic [31:0]       r_last_edge, n_last_edge;
    logic              r_first_edge, n_first_edge;
    logic signed [25:0] r_accum, n_accum;
    logic [1:0]        r_phase, n_phase;

    // Pending record bytes of a long gap, low byte first.
    logic [1:0]  r_run_cnt, n_run_cnt;
    logic [23:0] r_run_bytes, n_run_bytes;

    logic    r_out_valid;
    t_result r_out, n_out;

    logic               can_fire, take, emit_run;
    logic [31:0]        pos_inc, len_upd, gap;
    logic [23:0]        gap_sat;
    logic               motor_chg, press_chg, pressed;
    t_mode              press_code, mid_drive, fin_drive;
    logic signed [25:0] left_ext, pulse_sum;
    logic               pulse_done;

    assign can_fire    = !r_out_valid || i_result_ready;
    assign take        = can_fire && (r_run_cnt == 2'd0) && i_item_valid;
    assign emit_run    = can_fire && (r_run_cnt != 2'd0);
    assign o_item_take = take;

    assign pos_inc  = r_pos + 32'd1;
    assign len_upd  = (pos_inc > r_len) ? pos_inc : r_len;
    assign gap      = i_item.edge_cycle - r_last_edge;
    assign gap_sat  = (gap[31:24] != 8'd0) ? LONG_MAX : gap[23:0];
    assign left_ext = 26'(i_item.leftover_cycles);

    always_comb begin
        n_motor      = r_motor;
        n_button     = r_button;
        n_drive      = r_drive;
        n_pos        = r_pos;
        n_len        = r_len;
        n_last_edge  = r_last_edge;
        n_first_edge = r_first_edge;
        n_accum      = r_accum;
        n_phase      = r_phase;
        n_run_cnt    = r_run_cnt;
        n_run_bytes  = r_run_bytes;
        motor_chg    = 1'b0;
        press_chg    = 1'b0;
        pressed      = 1'b0;
        press_code   = MODE_STOP;
        mid_drive    = r_drive;
        fin_drive    = r_drive;
        pulse_sum    = '0;
        pulse_done   = 1'b0;
        n_out        = '0;
        n_out.out_kind    = KIND_STATUS;
        n_out.last_of_run = 1'b1;

        if (emit_run) begin
            n_pos             = pos_inc;
            n_len             = len_upd;
            n_run_cnt         = r_run_cnt - 2'd1;
            n_run_bytes       = r_run_bytes >> 8;
            n_out.out_kind    = KIND_RECORD;
            n_out.record_byte = r_run_bytes[7:0];
            n_out.last_of_run = (r_run_cnt == 2'd1);
        end else if (take) begin
            case (i_item.func)
                FUNC_CTRL: begin
                    // Motor first, then the button, each re-evaluating the drive.
                    motor_chg = (r_motor != i_item.motor);
                    n_motor   = i_item.motor;
                    mid_drive = drive_of(r_image, n_motor, r_button);
                    if (i_item.button_code <= BTN_RECORD) begin
                        pressed    = 1'b1;
                        press_code = i_item.button_code[1:0];
                    end else if (i_item.button_code == BTN_REWIND ||
                                 i_item.button_code == BTN_FORWARD) begin
                        pressed    = 1'b1;
                        press_code = MODE_STOP;
                        if (r_image) begin
                            n_pos = (i_item.button_code == BTN_REWIND) ? 32'd0 : r_len;
                        end
                    end
                    press_chg = pressed && (r_button != press_code);
                    if (press_chg) begin
                        n_button = (press_code == MODE_REC && r_protect) ? MODE_STOP
                                                                          : press_code;
                    end
                    fin_drive = drive_of(r_image, n_motor, n_button);
                    if (press_chg) begin
                        n_drive = fin_drive;
                    end else if (motor_chg) begin
                        n_drive = mid_drive;
                    end
                    if ((motor_chg && mid_drive != MODE_PLAY) ||
                        (press_chg && fin_drive != MODE_PLAY)) begin
                        n_accum = -26'sd1;
                        n_phase = 2'd0;
                    end
                    if (motor_chg || press_chg) begin
                        n_first_edge = 1'b1;
                    end
                    if (i_item.button_code == BTN_REWIND ||
                        i_item.button_code == BTN_FORWARD) begin
                        n_accum = -26'sd1;
                        n_phase = 2'd0;
                    end
                end
                FUNC_EDGE: begin
                    if (r_image && r_drive == MODE_REC && !r_first_edge) begin
                        n_last_edge = i_item.edge_cycle;
                        if (gap >= MIN_GAP) begin
                            n_pos          = pos_inc;
                            n_len          = len_upd;
                            n_out.out_kind = KIND_RECORD;
                            if (gap <= SHORT_MAX) begin
                                n_out.record_byte = gap[10:3];
                            end else if (r_version) begin
                                // Overflow code, then three length bytes.
                                n_run_cnt         = 2'd3;
                                n_run_bytes       = gap_sat;
                                n_out.last_of_run = 1'b0;
                            end
                        end
                    end else if (r_image && r_drive == MODE_REC) begin
                        n_last_edge  = i_item.edge_cycle;
                        n_first_edge = 1'b0;
                    end
                end
                FUNC_PLAY: begin
                    if (r_image && r_drive == MODE_PLAY) begin
                        if (i_item.end_of_tape) begin
                            n_button       = MODE_STOP;
                            n_drive        = drive_of(r_image, r_motor, MODE_STOP);
                            n_accum        = -26'sd1;
                            n_phase        = 2'd0;
                            n_first_edge   = 1'b1;
                            n_out.out_kind = KIND_EOT;
                        end else begin
                            n_pos = pos_inc;
                            case (r_phase)
                                2'd0: begin
                                    if (i_item.tape_byte != 8'd0) begin
                                        pulse_sum  = left_ext +
                                                     {15'd0, i_item.tape_byte, 3'd0};
                                        pulse_done = 1'b1;
                                    end else if (r_version) begin
                                        n_accum = left_ext;
                                        n_phase = 2'd1;
                                    end else begin
                                        pulse_sum  = left_ext + OVERFLOW_LEN;
                                        pulse_done = 1'b1;
                                    end
                                end
                                2'd1: begin
                                    n_accum = r_accum + {18'd0, i_item.tape_byte};
                                    n_phase = 2'd2;
                                end
                                2'd2: begin
                                    n_accum = r_accum + {10'd0, i_item.tape_byte, 8'd0};
                                    n_phase = 2'd3;
                                end
                                default: begin
                                    pulse_sum  = r_accum + {2'd0, i_item.tape_byte, 16'd0};
                                    pulse_done = 1'b1;
                                end
                            endcase
                            if (pulse_done) begin
                                // Negative totals clamp to an immediate pulse.
                                n_accum = pulse_sum[25] ? 26'sd0 : pulse_sum;
                                n_phase = 2'd0;
                                n_out.out_kind     = KIND_PULSE;
                                n_out.pulse_cycles = n_accum[23:0];
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        n_out.drive_mode    = n_drive;
        n_out.tape_position = n_pos;
        n_out.tape_length   = n_len;

        // A length write restarts the tape at its beginning.
        if (i_cfg_we && i_cfg_index == CFG_INIT_LEN) begin
            n_pos = 32'd0;
            n_len = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_version    <= 1'b1;
            r_protect    <= 1'b1;
            r_image      <= 1'b0;
            r_motor      <= 1'b0;
            r_button     <= MODE_STOP;
            r_drive      <= MODE_STOP;
            r_pos        <= 32'd0;
            r_len        <= 32'd0;
            r_last_edge  <= 32'd0;
            r_first_edge <= 1'b1;
            r_accum      <= -26'sd1;
            r_phase      <= 2'd0;
            r_run_cnt    <= 2'd0;
            r_out_valid  <= 1'b0;
        end else begin
            r_motor      <= n_motor;
            r_button     <= n_button;
            r_drive      <= n_drive;
            r_pos        <= n_pos;
            r_len        <= n_len;
            r_last_edge  <= n_last_edge;
            r_first_edge <= n_first_edge;
            r_accum      <= n_accum;
            r_phase      <= n_phase;
            r_run_cnt    <= n_run_cnt;
            if (take || emit_run) begin
                r_out_valid <= 1'b1;
            end else if (i_result_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_VERSION:  r_version <= i_cfg_data[0];
                    CFG_PROTECT:  r_protect <= i_cfg_data[0];
                    CFG_IMAGE:    r_image   <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_run_bytes <= n_run_bytes;
        if (take || emit_run) begin
            r_out <= n_out;
        end
    end

    assign o_result_valid   = r_out_valid;
    assign o_result         = r_out;
    assign o_status.drive    = r_drive;
    assign o_status.button   = r_button;
    assign o_status.motor    = r_motor;
    assign o_status.run_busy = (r_run_cnt != 2'd0);

endmodule

### rtl/tape_pulse_codec.sv
// Top level of the tape pulse codec: input register, core and result channel.
//
// The codec models a cassette drive working on raw pulse images. Control items
// set the motor level and the pressed button; the drive plays or records only
// while an image is mounted, the motor is on and the matching button is down.
// During playback each image byte turns into the length of the next read pulse,
// including the long 24-bit form of format version 1, and end of tape stops the
// drive. During recording the time between write edges is coded into image bytes,
// reported one result item at a time. Every accepted item yields between one and
// four result items; the last one carries last_of_run. Each result also reports
// the drive mode, the tape position and the tape length as they stand after it.
// An accepted item is held in the input register and its first result is then
// loaded into the result register, from which it can be taken. The core writes
// one result per cycle into the result register while the result side takes
// them, so a long recorded gap in version 1 occupies it for its four results,
// while every other item has a single result. With the result side always ready,
// a new item is accepted every cycle except while the bytes of a long gap are
// pending. A stalled result holds the item in the input register, which takes a
// further item only while it is empty. Configuration writes are taken in every
// cycle and are meant to be issued only while no item is in flight.
module tape_pulse_codec
    import tpc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    tpc_in_if.sink     i_in,
    tpc_cfg_if.sink    i_cfg,
    tpc_out_if.source  o_out
);

    logic         item_valid;
    logic         item_take;
    t_in_item     item;
    logic         result_valid;
    t_result      result;
    t_core_status status;

    tpc_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (item_take),
        .o_valid (item_valid),
        .o_item  (item)
    );

    // The register file never stalls a write.
    assign i_cfg.ready = 1'b1;

    tpc_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item_valid   (item_valid),
        .i_item         (item),
        .o_item_take    (item_take),
        .i_cfg_we       (i_cfg.valid),
        .i_cfg_index    (i_cfg.index),
        .i_cfg_data     (i_cfg.data),
        .o_result_valid (result_valid),
        .o_result       (result),
        .i_result_ready (o_out.ready),
        .o_status       (status)
    );

    assign o_out.valid         = result_valid;
    assign o_out.out_kind      = result.out_kind;
    assign o_out.record_byte   = result.record_byte;
    assign o_out.pulse_cycles  = result.pulse_cycles;
    assign o_out.last_of_run   = result.last_of_run;
    assign o_out.drive_mode    = result.drive_mode;
    assign o_out.tape_position = result.tape_position;
    assign o_out.tape_length   = result.tape_length;

    // A running drive always matches the held button with the motor on.
    a_drive_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.drive != MODE_STOP |-> status.drive == status.button && status.motor)
        else $error("drive runs without matching button and motor");

    // Pending record bytes only exist behind a result still on the output.
    a_run_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.run_busy |-> o_out.valid)
        else $error("pending record bytes with an empty result register");

    // Once a result is taken while bytes are pending, the next is a record byte.
    a_run_next_rec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.run_busy && o_out.valid && o_out.ready |=>
            o_out.valid && o_out.out_kind == KIND_RECORD)
        else $error("long gap bytes not delivered in sequence");

    // A pulse is only ever produced while the drive keeps playing.
    a_pulse_in_play: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.out_kind == KIND_PULSE |-> o_out.drive_mode == MODE_PLAY)
        else $error("pulse reported outside playback");

endmodule
